// File: src/rsqe_pkg.sv
// Package for the reciprocal square root estimate block.
// Holds the stage structs and the 32-entry base/slope table. No dependencies.
package rsqe_pkg;

  localparam logic [63:0] InfBits  = 64'h7FF0000000000000;
  localparam logic [63:0] QnanBits = 64'h7FF8000000000000;
  localparam logic [12:0] ExpBiasSum = 13'd3068;

  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic [12:0] exp_s;
    logic [51:0] frac;
  } rsqe_norm_t;

  typedef struct packed {
    logic        special;
    logic [63:0] special_bits;
    logic [10:0] rexp;
    logic [26:0] base;
    logic [11:0] dec_mag;
    logic [10:0] step;
  } rsqe_idx_t;

  function automatic logic [26:0] rom_base(input logic [4:0] sel);
    logic [26:0] b;
    case (sel)
      5'd0:  b = 27'h1a7e800;  5'd1:  b = 27'h17cb800;  5'd2:  b = 27'h1552800;
      5'd3:  b = 27'h130c000;  5'd4:  b = 27'h10f2000;  5'd5:  b = 27'h0eff000;
      5'd6:  b = 27'h0d2e000;  5'd7:  b = 27'h0b7c000;  5'd8:  b = 27'h09e5000;
      5'd9:  b = 27'h0867000;  5'd10: b = 27'h06ff000;  5'd11: b = 27'h05ab800;
      5'd12: b = 27'h046a000;  5'd13: b = 27'h0339800;  5'd14: b = 27'h0218800;
      5'd15: b = 27'h0105800;  5'd16: b = 27'h3ffa000;  5'd17: b = 27'h3c29000;
      5'd18: b = 27'h38aa000;  5'd19: b = 27'h3572000;  5'd20: b = 27'h3279000;
      5'd21: b = 27'h2fb7000;  5'd22: b = 27'h2d26000;  5'd23: b = 27'h2ac0000;
      5'd24: b = 27'h2881000;  5'd25: b = 27'h2665000;  5'd26: b = 27'h2468000;
      5'd27: b = 27'h2287000;  5'd28: b = 27'h20c1000;  5'd29: b = 27'h1f12000;
      5'd30: b = 27'h1d79000;  default: b = 27'h1bf4000;
    endcase
    return b;
  endfunction

  function automatic logic [11:0] rom_dec(input logic [4:0] sel);
    logic [11:0] d;
    case (sel)
      5'd0:  d = 12'h568; 5'd1:  d = 12'h4f3; 5'd2:  d = 12'h48d; 5'd3:  d = 12'h435;
      5'd4:  d = 12'h3e7; 5'd5:  d = 12'h3a2; 5'd6:  d = 12'h365; 5'd7:  d = 12'h32e;
      5'd8:  d = 12'h2fc; 5'd9:  d = 12'h2d0; 5'd10: d = 12'h2a8; 5'd11: d = 12'h283;
      5'd12: d = 12'h261; 5'd13: d = 12'h243; 5'd14: d = 12'h226; 5'd15: d = 12'h20b;
      5'd16: d = 12'h7a4; 5'd17: d = 12'h700; 5'd18: d = 12'h670; 5'd19: d = 12'h5f2;
      5'd20: d = 12'h584; 5'd21: d = 12'h524; 5'd22: d = 12'h4cc; 5'd23: d = 12'h47e;
      5'd24: d = 12'h43a; 5'd25: d = 12'h3fa; 5'd26: d = 12'h3c2; 5'd27: d = 12'h38e;
      5'd28: d = 12'h35e; 5'd29: d = 12'h332; 5'd30: d = 12'h30a; default: d = 12'h2e6;
    endcase
    return d;
  endfunction

endpackage

// File: src/rsqe_norm.sv
// Stage 1: classifies the operand and normalizes denormals.
// Depends on rsqe_pkg.
module rsqe_norm import rsqe_pkg::*; (
  input  logic [63:0] operand,
  output rsqe_norm_t  norm
);

  logic        sign;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic [5:0]  lz;
  logic        found;

  always_comb begin
    sign  = operand[63];
    bexp  = operand[62:52];
    frac  = operand[51:0];
    lz    = 6'd0;
    found = 1'b0;
    for (int i = 51; i >= 0; i--) begin
      if (!found && frac[i]) begin
        found = 1'b1;
        lz    = 6'(51 - i);
      end
    end
    norm.special      = 1'b1;
    norm.special_bits = QnanBits;
    norm.exp_s        = {2'b00, bexp};
    norm.frac         = frac;
    if (bexp == 11'd0 && frac == '0) begin
      norm.special_bits = {sign, InfBits[62:0]};
    end else if (bexp == 11'h7FF) begin
      if (frac == '0 && !sign) norm.special_bits = '0;
    end else if (!sign) begin
      norm.special = 1'b0;
      if (bexp == 11'd0) begin
        // shifts = lz + 1; e = 1 - shifts = -lz
        norm.exp_s = 13'(-{7'd0, lz});
        norm.frac  = 52'(frac << (lz + 6'd1));
      end
    end
  end

endmodule

// File: src/rsqe_index.sv
// Stage 2: result exponent and table lookup.
// Depends on rsqe_pkg.
module rsqe_index import rsqe_pkg::*; (
  input  rsqe_norm_t norm,
  output rsqe_idx_t  idx
);

  logic [12:0] t;
  logic [4:0]  sel;

  always_comb begin
    t   = 13'(ExpBiasSum - norm.exp_s);
    sel = {norm.exp_s[0], norm.frac[51:48]};
    idx.special      = norm.special;
    idx.special_bits = norm.special_bits;
    idx.rexp         = t[11:1];
    idx.base         = rom_base(sel);
    idx.dec_mag      = rom_dec(sel);
    idx.step         = norm.frac[47:37];
  end

endmodule

// File: src/rsqe_mant.sv
// Stage 3: multiply-subtract for the mantissa and result assembly.
// Depends on rsqe_pkg.
module rsqe_mant import rsqe_pkg::*; (
  input  rsqe_idx_t   idx,
  output logic [63:0] result
);

  logic [22:0] prod;
  logic [26:0] mant;

  always_comb begin
    prod = 23'(idx.dec_mag) * 23'(idx.step);
    mant = idx.base - 27'(prod);
    if (idx.special) result = idx.special_bits;
    else             result = {1'b0, idx.rexp, mant[25:0], 26'd0};
  end

endmodule

// File: src/reciprocal_sqrt_estimate_top.sv
// Reciprocal square root estimate of a raw IEEE double, three-stage pipeline.
// Depends on rsqe_pkg, rsqe_norm, rsqe_index, rsqe_mant.
//
// Input beat: in_valid/in_stall with in_operand_bits (64-bit double pattern).
// Result beat: out_valid/out_stall with out_estimate_bits.
// Each operand yields exactly one result, in order.
// Stages in order: normalize, lookup, multiply-subtract, each registered.
// Throughput: one beat per cycle unless a stalled output has filled the pipeline;
// each stage is set by its own logic: leading-zero shift, table read, 12x11 multiply.
// A stage advances when it is empty or the stage after it advances, so the
// pipeline holds up to three beats; a stalled output holds its beat stable
// and in_stall rises only once all three stages are full.
// Reset (rst_n low, synchronous) clears every valid bit; no other state.
// The block has no configuration.
module reciprocal_sqrt_estimate_top import rsqe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_operand_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_estimate_bits
);

  rsqe_norm_t  norm_nxt, norm_r;
  rsqe_idx_t   idx_nxt, idx_r;
  logic [63:0] res_nxt, res_r;
  logic        v1_r, v2_r, v3_r;
  logic        adv1, adv2, adv3;

  rsqe_norm  u_norm  (.operand(in_operand_bits), .norm(norm_nxt));
  rsqe_index u_index (.norm(norm_r), .idx(idx_nxt));
  rsqe_mant  u_mant  (.idx(idx_r), .result(res_nxt));

  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_stall = !adv1;
  assign out_valid = v3_r;
  assign out_estimate_bits = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) norm_r <= norm_nxt;
    if (adv2) idx_r  <= idx_nxt;
    if (adv3) res_r  <= res_nxt;
  end

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_estimate_bits))
    else $error("result changed under stall");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_stall)
    else $error("input stalled with room in pipeline");
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !out_stall |=> v3_r)
    else $error("beat lost between stages");

endmodule

// File: tb/testbench.sv
// Testbench for reciprocal_sqrt_estimate_top: drives operand beats, predicts each estimate.
// Depends on rsqe_pkg and the reciprocal_sqrt_estimate_top RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_operand_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_estimate_bits;

  logic [63:0] expected_estimates[$];
  int          fail_count = 0;
  bit          quiet_sender = 1'b0;
  bit          quiet_receiver = 1'b0;
  int          hold_cycles = 0;

  reciprocal_sqrt_estimate_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_operand_bits(in_operand_bits),
    .out_valid(out_valid), .out_stall(out_stall), .out_estimate_bits(out_estimate_bits)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rsqrt_estimate(input logic [63:0] x);
    logic [51:0] frac;
    logic [10:0] bexp;
    int          e;
    int          shifts;
    logic [31:0] rexp_t;
    logic [15:0] idx;
    logic [4:0]  sel;
    int          step;
    int          mant;
    logic [31:0] mant_u;
    logic [63:0] wide;
    frac = x[51:0];
    bexp = x[62:52];
    if (bexp == 0 && frac == 0) return {x[63], 63'h7FF0000000000000};
    if (bexp == 11'h7FF) begin
      if (frac == 0 && !x[63]) return 64'h0;
      return 64'h7FF8000000000000;
    end
    if (x[63]) return 64'h7FF8000000000000;
    e = bexp;
    if (bexp == 0) begin
      wide = {12'h0, frac};
      shifts = 0;
      while (!wide[52]) begin
        wide = wide << 1;
        shifts++;
      end
      frac = wide[51:0];
      e = 1 - shifts;
    end
    rexp_t = 32'(3068 - e);
    idx = {e[0], frac[51:37]};
    sel = idx[15:11];
    step = idx[10:0];
    mant = int'(rsqe_pkg::rom_base(sel)) - int'(rsqe_pkg::rom_dec(sel)) * step;
    mant_u = mant;
    wide = {32'h0, mant_u} << 26;
    return {1'b0, rexp_t[11:1], wide[51:0]};
  endfunction

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= !quiet_receiver && ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_estimates.size() == 0) begin
        $error("unexpected beat: estimate_bits=%h", out_estimate_bits);
        fail_count++;
      end else begin
        if (out_estimate_bits !== expected_estimates[0]) begin
          $error("estimate_bits expected %h actual %h", expected_estimates[0],
                 out_estimate_bits);
          fail_count++;
        end
        void'(expected_estimates.pop_front());
      end
    end
  end

  task automatic send_operand(input logic [63:0] op);
    while (!quiet_sender && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operand_bits <= op;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_estimates.push_back(rsqrt_estimate(op));
    @(negedge clk);
  endtask

  function automatic logic [63:0] random_operand();
    logic [63:0] op;
    int          kind;
    op = {$urandom, $urandom};
    kind = $urandom_range(9);
    case (kind)
      0: op[62:52] = 11'h0;
      1: op[62:52] = 11'h7FF;
      2: op[62:0] = 63'h0;
      3: op[62:52] = 11'($urandom_range(2)) + 11'h7FC;
      4: op[62:52] = 11'($urandom_range(2));
      5: op[51:0] = op[51:0] >> $urandom_range(51);
      default: op[63] = ($urandom_range(9) == 0);
    endcase
    return op;
  endfunction

  task automatic test_special_operands();
    send_operand(64'h0000000000000000);
    send_operand(64'h8000000000000000);
    send_operand(64'h7FF0000000000000);
    send_operand(64'hFFF0000000000000);
    send_operand(64'h7FF8000000000000);
    send_operand(64'h7FF0000000000001);
    send_operand(64'hFFFFFFFFFFFFFFFF);
    send_operand(64'hBFF0000000000000);
    send_operand(64'h8000000000000001);
  endtask

  task automatic test_extreme_operands();
    send_operand(64'h0000000000000001);
    send_operand(64'h000FFFFFFFFFFFFF);
    send_operand(64'h0008000000000000);
    send_operand(64'h0010000000000000);
    send_operand(64'h7FEFFFFFFFFFFFFF);
    send_operand(64'h3FF0000000000000);
    send_operand(64'h4000000000000000);
    send_operand(64'h3FFFFFFFFFFFFFFF);
    send_operand(64'h5555555555555555);
    send_operand(64'h2AAAAAAAAAAAAAAA);
  endtask

  task automatic test_random_operands(input int count);
    repeat (count) send_operand(random_operand());
  endtask

  task automatic test_full_pipeline_backpressure();
    hold_cycles = 40;
    quiet_sender = 1'b1;
    repeat (30) send_operand(random_operand());
    quiet_sender = 1'b0;
  endtask

  task automatic test_drain_then_burst();
    in_valid <= 1'b0;
    while (expected_estimates.size() != 0) @(negedge clk);
    quiet_sender = 1'b1;
    quiet_receiver = 1'b1;
    repeat (200) send_operand(random_operand());
    quiet_sender = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_special_operands();
    test_extreme_operands();
    test_random_operands(700);
    test_full_pipeline_backpressure();
    test_drain_then_burst();
    test_random_operands(850);
    in_valid <= 1'b0;
    while (expected_estimates.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && expected_estimates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: reciprocal_sqrt_estimate_top.f
src/rsqe_pkg.sv
src/rsqe_norm.sv
src/rsqe_index.sv
src/rsqe_mant.sv
src/reciprocal_sqrt_estimate_top.sv
tb/testbench.sv
